[src/mst_pkg.sv]
// ============================================================================
// mst_pkg: shared types, constants and functions of the MLP trainer
// fixed point helpers, sigmoid table builder, action and result codes
// ============================================================================
package mst_pkg;

    localparam int MAX_LAYERS  = 4;
    localparam int MAX_NEURONS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int LR_BITS     = 16;
    localparam int SIG_ENTRIES = 1024;

    localparam int VW       = 24;
    localparam int ACC_W    = 50;
    localparam int OP_W     = VW + 1;
    localparam int IDX_W    = $clog2(MAX_NEURONS);
    localparam int LAY_W    = $clog2(MAX_LAYERS);
    localparam int NADDR_W  = LAY_W + IDX_W;
    localparam int NDEPTH   = MAX_LAYERS * MAX_NEURONS;
    localparam int WDEPTH   = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
    localparam int WADDR_W  = $clog2(WDEPTH);
    localparam int SIG_AW   = $clog2(SIG_ENTRIES);
    localparam int SIG_W    = FRAC_BITS + 1;
    localparam int SIG_HALF = SIG_ENTRIES / 2;
    localparam int SIG_SHIFT = FRAC_BITS - $clog2(SIG_ENTRIES / 16);
    localparam int CLR_W    = $clog2(SIG_ENTRIES > WDEPTH ? SIG_ENTRIES : WDEPTH);
    localparam int LR_W     = 16;

    // actions
    localparam logic [2:0] ACT_WR_W = 3'd0;
    localparam logic [2:0] ACT_WR_B = 3'd1;
    localparam logic [2:0] ACT_RD_W = 3'd2;
    localparam logic [2:0] ACT_RD_B = 3'd3;
    localparam logic [2:0] ACT_IN   = 3'd4;
    localparam logic [2:0] ACT_TGT  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_NET  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_LAYERS = 3'd0;
    localparam logic [2:0] REG_W0     = 3'd1;
    localparam logic [2:0] REG_W1     = 3'd2;
    localparam logic [2:0] REG_W2     = 3'd3;
    localparam logic [2:0] REG_W3     = 3'd4;
    localparam logic [2:0] REG_LR     = 3'd5;

    typedef struct packed {
        logic [LAY_W-1:0]                  top;
        logic [MAX_LAYERS-1:0][IDX_W-1:0]  wm1;
        logic [LR_W-1:0]                   lr;
    } t_cfg;

    typedef logic [SIG_ENTRIES-1:0][SIG_W-1:0] t_sig_tab;

    // saturate a wide sum to the value width
    function automatic logic signed [VW-1:0] sat_v(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-VW:0] hi;
        hi = v[ACC_W-1:VW-1];
        if (hi == '0 || hi == '1) begin
            return v[VW-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(VW-1){1'b0}}};
        end else begin
            return {1'b0, {(VW-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sx_v(input logic signed [VW-1:0] v);
        return ACC_W'(v);
    endfunction

    // table index: floor(z * entries/16) + half, clamped
    function automatic logic [SIG_AW-1:0] sig_index(input logic signed [VW-1:0] z);
        logic signed [VW-1:0] s;
        logic signed [VW:0]   i;
        s = z >>> SIG_SHIFT;
        i = (VW+1)'(s) + (VW+1)'(SIG_HALF);
        if (i < 0) begin
            return '0;
        end else if (i > (VW+1)'(SIG_ENTRIES - 1)) begin
            return SIG_AW'(SIG_ENTRIES - 1);
        end else begin
            return i[SIG_AW-1:0];
        end
    endfunction

    // elaboration only: unsigned quotient by shift and subtract
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q, r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // elaboration only: sigmoid samples from a Q2.30 series for exp
    function automatic t_sig_tab build_sig();
        longint unsigned one, step, term, pos, neg, base, e, den, s;
        t_sig_tab t;
        one  = 64'd1 << 30;
        step = (64'd16 << 30) / SIG_ENTRIES;
        term = one;
        pos  = one;
        neg  = 0;
        e    = one;
        t    = '0;
        for (int n = 1; n <= 10; n++) begin
            term = div_u64((term * step) >> 30, 64'(n));
            if (n % 2 == 1) neg = neg + term;
            else pos = pos + term;
        end
        base = pos - neg;
        for (int k = 0; k <= SIG_HALF; k++) begin
            den = one + e;
            s = div_u64((64'd1 << (30 + FRAC_BITS)) + (den >> 1), den);
            if (k < SIG_HALF) t[SIG_HALF + k] = SIG_W'(s);
            if (k > 0) t[SIG_HALF - k] = SIG_W'((64'd1 << FRAC_BITS) - s);
            e = (e * base) >> 30;
        end
        return t;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig();

endpackage

[src/mst_ram.sv]
// ============================================================================
// mst_ram: generic single write port memory
// one write and one read address per cycle, read data registered
// ============================================================================
module mst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/mst_cfg.sv]
// ============================================================================
// mst_cfg: configuration registers
// APB register file with clamped layer count and widths for the sequencer
// ============================================================================
module mst_cfg import mst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    logic [2:0]  r_layers;
    logic [4:0]  r_w [MAX_LAYERS];
    logic [15:0] r_lr;
    logic [2:0]  reg_idx;
    logic        wr;

    assign reg_idx = paddr[4:2];
    assign wr      = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers <= 3'd3;
            for (int i = 0; i < MAX_LAYERS; i++) r_w[i] <= 5'd16;
            r_lr <= 16'd6554;
        end else if (wr) begin
            case (reg_idx)
                REG_LAYERS: r_layers <= pwdata[2:0];
                REG_W0:     r_w[0]   <= pwdata[4:0];
                REG_W1:     r_w[1]   <= pwdata[4:0];
                REG_W2:     r_w[2]   <= pwdata[4:0];
                REG_W3:     r_w[3]   <= pwdata[4:0];
                REG_LR:     r_lr     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LAYERS: prdata = {29'd0, r_layers};
            REG_W0:     prdata = {27'd0, r_w[0]};
            REG_W1:     prdata = {27'd0, r_w[1]};
            REG_W2:     prdata = {27'd0, r_w[2]};
            REG_W3:     prdata = {27'd0, r_w[3]};
            REG_LR:     prdata = {16'd0, r_lr};
            default:    prdata = '0;
        endcase
    end

    // index of the output layer and width minus one of each layer
    always_comb begin
        if (r_layers < 3'd2) o_cfg.top = LAY_W'(1);
        else if (r_layers > 3'd4) o_cfg.top = LAY_W'(3);
        else o_cfg.top = LAY_W'(r_layers - 3'd1);
        for (int i = 0; i < MAX_LAYERS; i++) begin
            if (r_w[i] == 5'd0) o_cfg.wm1[i] = '0;
            else if (r_w[i] > 5'(MAX_NEURONS)) o_cfg.wm1[i] = IDX_W'(MAX_NEURONS - 1);
            else o_cfg.wm1[i] = IDX_W'(r_w[i] - 5'd1);
        end
        o_cfg.lr = r_lr;
    end
endmodule

[src/mlp_sigmoid_sgd_trainer.sv]
// ============================================================================
// mlp_sigmoid_sgd_trainer: sigmoid MLP with per-sample SGD training
// sequencer around one shared 25x25 multiplier and on-chip weight memories
// ============================================================================
// After reset the block runs a clearing pass that clears weights and
// biases and loads the sigmoid table; it stalls input meanwhile. A read
// passes through S_RD and S_RDO before its result is registered at the
// output. A forward pass reads, multiplies and accumulates each weight of
// the active layers, applies the sigmoid to each neuron, then emits each
// output. Training works through the output error terms, the
// back-propagated weights, the neuron deltas, the bias updates and the
// weight updates, using the single multiplier and the one read port of each
// memory; the block takes one transaction at a time.
module mlp_sigmoid_sgd_trainer import mst_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_action,
    input  logic [1:0]           i_layer,
    input  logic [3:0]           i_row,
    input  logic [3:0]           i_col,
    input  logic signed [23:0]   i_value,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_kind,
    output logic signed [23:0]   o_out_value,
    output logic [3:0]           o_out_index,
    output logic                 o_final_res
);
    localparam logic [5:0] S_CLR    = 6'd0;
    localparam logic [5:0] S_IDLE   = 6'd1;
    localparam logic [5:0] S_RD     = 6'd2;
    localparam logic [5:0] S_RDO    = 6'd3;
    localparam logic [5:0] S_FI_RD  = 6'd4;
    localparam logic [5:0] S_FI_D   = 6'd5;
    localparam logic [5:0] S_SIGW   = 6'd6;
    localparam logic [5:0] S_FB_RD  = 6'd7;
    localparam logic [5:0] S_FB_D   = 6'd8;
    localparam logic [5:0] S_FM_RD  = 6'd9;
    localparam logic [5:0] S_FM_MUL = 6'd10;
    localparam logic [5:0] S_FM_ACC = 6'd11;
    localparam logic [5:0] S_F_SIG  = 6'd12;
    localparam logic [5:0] S_FO_RD  = 6'd13;
    localparam logic [5:0] S_FO_OUT = 6'd14;
    localparam logic [5:0] S_TE_RD  = 6'd15;
    localparam logic [5:0] S_TE_MUL = 6'd16;
    localparam logic [5:0] S_TE_ACC = 6'd17;
    localparam logic [5:0] S_D_RD   = 6'd18;
    localparam logic [5:0] S_D_A    = 6'd19;
    localparam logic [5:0] S_D_DZ   = 6'd20;
    localparam logic [5:0] S_DK_RD  = 6'd21;
    localparam logic [5:0] S_DK_MUL = 6'd22;
    localparam logic [5:0] S_DK_ACC = 6'd23;
    localparam logic [5:0] S_D_MD   = 6'd24;
    localparam logic [5:0] S_D_WR   = 6'd25;
    localparam logic [5:0] S_U_RD   = 6'd26;
    localparam logic [5:0] S_U_B    = 6'd27;
    localparam logic [5:0] S_U_BW   = 6'd28;
    localparam logic [5:0] S_UK_RD  = 6'd29;
    localparam logic [5:0] S_UK_G   = 6'd30;
    localparam logic [5:0] S_UK_GS  = 6'd31;
    localparam logic [5:0] S_UK_L   = 6'd32;
    localparam logic [5:0] S_UK_WW  = 6'd33;
    localparam logic [5:0] S_T_OUT  = 6'd34;

    localparam logic signed [OP_W-1:0] ONE_Q = OP_W'(1) <<< FRAC_BITS;

    t_cfg cfg;

    mst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [5:0]         r_state, n_state;
    logic [LAY_W-1:0]   r_l, n_l;
    logic [IDX_W-1:0]   r_j, n_j, r_k, n_k;
    logic [CLR_W-1:0]   r_clr;
    logic [2:0]         r_op;
    logic [1:0]         r_layer;
    logic [3:0]         r_row, r_col;

    logic signed [ACC_W-1:0] r_acc, r_err, r_prod;
    logic signed [VW-1:0]    r_a, r_dz, r_da, r_d, r_b, r_g, r_w;
    logic signed [VW-1:0]    r_tgt [MAX_NEURONS];

    logic                    r_ovld;
    logic [1:0]              r_kind;
    logic signed [VW-1:0]    r_oval;
    logic [3:0]              r_oidx;
    logic                    r_ofin;

    logic in_acc, slot_free, emit;
    logic [1:0] e_kind;
    logic signed [VW-1:0] e_val;
    logic e_fin;

    logic j_last, kp_last, kn_last, at_top;
    logic [LAY_W-1:0] l_m1, l_p1;

    // memories
    logic               w_we, b_we, p_we, a_we, d_we, s_we;
    logic [WADDR_W-1:0] w_wa, w_ra;
    logic [NADDR_W-1:0] b_wa, b_ra, p_wa, p_ra, a_wa, a_ra, d_wa, d_ra;
    logic [SIG_AW-1:0]  s_wa, s_ra;
    logic [VW-1:0]      w_wd, b_wd, p_wd, a_wd, d_wd;
    logic [VW-1:0]      w_q, b_q, p_q, a_q, d_q;
    logic [SIG_W-1:0]   s_q, s_wd;

    logic signed [VW-1:0] w_qs, b_qs, p_qs, a_qs, d_qs, tgt_j, err_d;
    logic signed [OP_W-1:0] op_a, op_b;
    logic signed [ACC_W-1:0] prod;
    logic lr_mul;

    assign w_qs = $signed(w_q);
    assign b_qs = $signed(b_q);
    assign p_qs = $signed(p_q);
    assign a_qs = $signed(a_q);
    assign d_qs = $signed(d_q);
    assign tgt_j = r_tgt[r_j];
    assign err_d = sat_v(sx_v(a_qs) - sx_v(tgt_j));

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign slot_free  = ~r_ovld | ~i_out_stall;

    assign l_m1    = r_l - LAY_W'(1);
    assign l_p1    = r_l + LAY_W'(1);
    assign j_last  = (r_j == cfg.wm1[r_l]);
    assign kp_last = (r_k == cfg.wm1[l_m1]);
    assign kn_last = (r_k == cfg.wm1[l_p1]);
    assign at_top  = (r_l == cfg.top);

    mst_ram #(.WIDTH(VW), .DEPTH(WDEPTH)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(w_ra), .o_rdata(w_q));
    mst_ram #(.WIDTH(VW), .DEPTH(NDEPTH)) u_bram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(b_wd),
        .i_raddr(b_ra), .o_rdata(b_q));
    mst_ram #(.WIDTH(VW), .DEPTH(NDEPTH)) u_pram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_q));
    mst_ram #(.WIDTH(VW), .DEPTH(NDEPTH)) u_aram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_wa), .i_wdata(a_wd),
        .i_raddr(a_ra), .o_rdata(a_q));
    mst_ram #(.WIDTH(VW), .DEPTH(NDEPTH)) u_dram (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_wa), .i_wdata(d_wd),
        .i_raddr(d_ra), .o_rdata(d_q));
    mst_ram #(.WIDTH(SIG_W), .DEPTH(SIG_ENTRIES)) u_sram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_q));

    // memory addressing
    always_comb begin
        w_we = 1'b0;
        w_wa = {l_m1, r_k, r_j};
        w_wd = sat_v(sx_v(r_w) - sx_v(sat_v(r_prod)));
        b_we = 1'b0;
        b_wa = {r_l, r_j};
        b_wd = sat_v(sx_v(r_b) - sx_v(sat_v(r_prod)));
        p_we = 1'b0;
        p_wa = {r_l, r_j};
        p_wd = sat_v(r_acc);
        s_we = 1'b0;
        s_wa = r_clr[SIG_AW-1:0];
        s_wd = SIG_TAB[r_clr[SIG_AW-1:0]];
        case (r_state)
            S_CLR: begin
                w_we = (r_clr < CLR_W'(WDEPTH));
                w_wa = r_clr[WADDR_W-1:0];
                w_wd = '0;
                b_we = (r_clr < CLR_W'(NDEPTH));
                b_wa = r_clr[NADDR_W-1:0];
                b_wd = '0;
                s_we = 1'b1;
            end
            S_IDLE: begin
                w_we = in_acc && i_action == ACT_WR_W && i_layer != 2'd0;
                w_wa = {i_layer - 2'd1, i_row, i_col};
                w_wd = i_value;
                b_we = in_acc && i_action == ACT_WR_B;
                b_wa = {i_layer, i_col};
                b_wd = i_value;
                p_we = in_acc && i_action == ACT_IN;
                p_wa = {LAY_W'(0), i_col};
                p_wd = i_value;
            end
            S_UK_WW: w_we = 1'b1;
            S_U_BW:  b_we = 1'b1;
            S_F_SIG: p_we = 1'b1;
            default: ;
        endcase

        case (r_state)
            S_RD, S_RDO:                           w_ra = {r_layer - 2'd1, r_row, r_col};
            S_DK_RD, S_DK_MUL, S_DK_ACC:           w_ra = {r_l, r_j, r_k};
            default:                               w_ra = {l_m1, r_k, r_j};
        endcase
        b_ra = (r_state == S_RD || r_state == S_RDO) ? {r_layer, r_col} : {r_l, r_j};
        p_ra = {r_l, r_j};
        case (r_state)
            S_FM_RD, S_FM_MUL, S_UK_RD, S_UK_G: a_ra = {l_m1, r_k};
            default:                            a_ra = {r_l, r_j};
        endcase
        case (r_state)
            S_DK_RD, S_DK_MUL:                  d_ra = {l_p1, r_k};
            default:                            d_ra = {r_l, r_j};
        endcase
        s_ra = (r_state == S_FI_D) ? sig_index(p_qs) : sig_index(sat_v(r_acc));

        a_we = (r_state == S_SIGW);
        a_wa = {r_l, r_j};
        a_wd = VW'(s_q);
        d_we = (r_state == S_D_WR);
        d_wa = {r_l, r_j};
        d_wd = sat_v(r_prod);
    end

    // shared multiplier
    always_comb begin
        lr_mul = 1'b0;
        op_a = OP_W'(a_qs);
        op_b = OP_W'(w_qs);
        case (r_state)
            S_TE_MUL: begin
                op_a = OP_W'(err_d);
                op_b = OP_W'(err_d);
            end
            S_D_A: begin
                op_a = OP_W'(a_qs);
                op_b = ONE_Q - OP_W'(a_qs);
            end
            S_DK_MUL: begin
                op_a = OP_W'(w_qs);
                op_b = OP_W'(d_qs);
            end
            S_D_MD: begin
                op_a = OP_W'(r_dz);
                op_b = OP_W'(r_da);
            end
            S_U_B: begin
                op_a = OP_W'(d_qs);
                op_b = $signed({{(OP_W-LR_W){1'b0}}, cfg.lr});
                lr_mul = 1'b1;
            end
            S_UK_G: begin
                op_a = OP_W'(a_qs);
                op_b = OP_W'(r_d);
            end
            S_UK_L: begin
                op_a = OP_W'(r_g);
                op_b = $signed({{(OP_W-LR_W){1'b0}}, cfg.lr});
                lr_mul = 1'b1;
            end
            default: ;
        endcase
        prod = op_a * op_b;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_l = r_l;
        n_j = r_j;
        n_k = r_k;
        emit = 1'b0;
        e_kind = KIND_READ;
        e_val = '0;
        e_fin = 1'b1;
        case (r_state)
            S_CLR: if (r_clr == CLR_W'(SIG_ENTRIES - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        ACT_RD_W, ACT_RD_B: n_state = S_RD;
                        ACT_IN: begin
                            if (i_last) begin
                                n_l = '0;
                                n_j = '0;
                                n_state = S_FI_RD;
                            end
                        end
                        ACT_TGT: begin
                            if (i_last) begin
                                n_l = cfg.top;
                                n_j = '0;
                                n_state = S_TE_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: n_state = S_RDO;
            S_RDO: begin
                emit = 1'b1;
                e_kind = KIND_READ;
                if (r_op == ACT_RD_W) e_val = (r_layer == 2'd0) ? '0 : w_qs;
                else e_val = b_qs;
                if (slot_free) n_state = S_IDLE;
            end
            S_FI_RD: n_state = S_FI_D;
            S_FI_D:  n_state = S_SIGW;
            S_SIGW: begin
                n_j = r_j + IDX_W'(1);
                if (r_l == '0) n_state = S_FI_RD;
                else n_state = S_FB_RD;
                if (j_last) begin
                    n_j = '0;
                    if (at_top) begin
                        n_state = S_FO_RD;
                    end else begin
                        n_l = l_p1;
                        n_state = S_FB_RD;
                    end
                end
            end
            S_FB_RD: n_state = S_FB_D;
            S_FB_D: begin
                n_k = '0;
                n_state = S_FM_RD;
            end
            S_FM_RD:  n_state = S_FM_MUL;
            S_FM_MUL: n_state = S_FM_ACC;
            S_FM_ACC: begin
                n_k = r_k + IDX_W'(1);
                n_state = kp_last ? S_F_SIG : S_FM_RD;
            end
            S_F_SIG: n_state = S_SIGW;
            S_FO_RD: n_state = S_FO_OUT;
            S_FO_OUT: begin
                emit = 1'b1;
                e_kind = KIND_NET;
                e_val = a_qs;
                e_fin = j_last;
                if (slot_free) begin
                    n_j = r_j + IDX_W'(1);
                    n_state = j_last ? S_IDLE : S_FO_RD;
                end
            end
            S_TE_RD:  n_state = S_TE_MUL;
            S_TE_MUL: n_state = S_TE_ACC;
            S_TE_ACC: begin
                n_j = r_j + IDX_W'(1);
                n_state = S_TE_RD;
                if (j_last) begin
                    n_j = '0;
                    n_state = S_D_RD;
                end
            end
            S_D_RD: n_state = S_D_A;
            S_D_A:  n_state = S_D_DZ;
            S_D_DZ: begin
                n_k = '0;
                n_state = at_top ? S_D_MD : S_DK_RD;
            end
            S_DK_RD:  n_state = S_DK_MUL;
            S_DK_MUL: n_state = S_DK_ACC;
            S_DK_ACC: begin
                n_k = r_k + IDX_W'(1);
                n_state = kn_last ? S_D_MD : S_DK_RD;
            end
            S_D_MD: n_state = S_D_WR;
            S_D_WR: begin
                n_j = r_j + IDX_W'(1);
                n_state = S_D_RD;
                if (j_last) begin
                    n_j = '0;
                    if (r_l == '0) begin
                        n_state = S_U_RD;
                    end else begin
                        n_l = l_m1;
                    end
                end
            end
            S_U_RD: n_state = S_U_B;
            S_U_B:  n_state = S_U_BW;
            S_U_BW, S_UK_WW: begin
                if (r_state == S_U_BW && r_l != '0) begin
                    n_k = '0;
                    n_state = S_UK_RD;
                end else if (r_state == S_UK_WW && !kp_last) begin
                    n_k = r_k + IDX_W'(1);
                    n_state = S_UK_RD;
                end else begin
                    n_j = r_j + IDX_W'(1);
                    n_state = S_U_RD;
                    if (j_last) begin
                        n_j = '0;
                        if (at_top) n_state = S_T_OUT;
                        else n_l = l_p1;
                    end
                end
            end
            S_UK_RD: n_state = S_UK_G;
            S_UK_G:  n_state = S_UK_GS;
            S_UK_GS: n_state = S_UK_L;
            S_UK_L:  n_state = S_UK_WW;
            S_T_OUT: begin
                emit = 1'b1;
                e_kind = KIND_DONE;
                e_val = sat_v(r_err);
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_l     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_l     <= n_l;
            r_j     <= n_j;
            r_k     <= n_k;
            if (r_state == S_CLR) r_clr <= r_clr + CLR_W'(1);
            if (emit && slot_free) r_ovld <= 1'b1;
            else if (!i_out_stall) r_ovld <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= lr_mul ? (prod >>> LR_BITS) : (prod >>> FRAC_BITS);
        if (in_acc) begin
            r_op    <= i_action;
            r_layer <= i_layer;
            r_row   <= i_row;
            r_col   <= i_col;
            if (i_action == ACT_TGT) r_tgt[i_col] <= i_value;
            if (i_action == ACT_TGT && i_last) r_err <= '0;
        end
        if (emit && slot_free) begin
            r_kind <= e_kind;
            r_oval <= e_val;
            r_oidx <= (e_kind == KIND_NET) ? r_j : 4'd0;
            r_ofin <= e_fin;
        end
        case (r_state)
            S_FB_D:   r_acc <= sx_v(b_qs);
            S_FM_ACC: r_acc <= r_acc + r_prod;
            S_TE_ACC: r_err <= r_err + r_prod;
            S_D_A:    r_a <= a_qs;
            S_D_DZ: begin
                r_dz  <= sat_v(r_prod);
                r_da  <= sat_v((sx_v(r_a) - sx_v(tgt_j)) <<< 1);
                r_acc <= '0;
            end
            S_DK_ACC: begin
                r_acc <= r_acc + r_prod;
                r_da  <= sat_v(r_acc + r_prod);
            end
            S_U_B: begin
                r_d <= d_qs;
                r_b <= b_qs;
            end
            S_UK_GS: begin
                r_g <= sat_v(r_prod);
                r_w <= w_qs;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovld;
    assign o_kind      = r_kind;
    assign o_out_value = r_oval;
    assign o_out_index = r_oidx;
    assign o_final_res = r_ofin;

    // network outputs never name a neuron beyond the output layer
    a_net_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_NET |-> o_out_index <= cfg.wm1[cfg.top])
        else $error("network output index beyond output layer");

    // read data and training results are single, final and unindexed
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_NET |-> o_final_res && o_out_index == 4'd0)
        else $error("single result not marked final");

    // the clearing pass runs once after reset
    a_clr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLR |=> r_state != S_CLR)
        else $error("clearing pass restarted");

    // last input element starts a forward pass
    a_fwd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_action == ACT_IN && i_last |=> r_state == S_FI_RD && o_in_stall)
        else $error("forward pass did not start");
endmodule
